@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RCAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RCAM_ASSERT(lbl, prop, msg)
`define RCAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rcam_pkg.sv @@
`default_nettype none
package rcam_pkg;

  localparam int MAX_STRIPES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SNR_W = 56;
  localparam int DIV_BITS = 4;
  localparam int DIV_STG = SNR_W / DIV_BITS;
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;
  localparam int LG_MIN = 9;
  localparam int LG_MAX = 20;

  localparam logic [3:0] PROF_SINGLE  = 4'd0;
  localparam logic [3:0] PROF_RAID0   = 4'd1;
  localparam logic [3:0] PROF_RAID1   = 4'd2;
  localparam logic [3:0] PROF_DUP     = 4'd3;
  localparam logic [3:0] PROF_RAID10  = 4'd4;
  localparam logic [3:0] PROF_RAID5   = 4'd5;
  localparam logic [3:0] PROF_RAID6   = 4'd6;
  localparam logic [3:0] PROF_RAID1C3 = 4'd7;
  localparam logic [3:0] PROF_RAID1C4 = 4'd8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] REG_CHUNK_START = 3'd0;
  localparam logic [2:0] REG_CHUNK_LEN   = 3'd1;
  localparam logic [2:0] REG_STRIPE_LG   = 3'd2;
  localparam logic [2:0] REG_STRIPE_CNT  = 3'd3;
  localparam logic [2:0] REG_COPIES      = 3'd4;
  localparam logic [2:0] REG_PROFILE     = 3'd5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OUTSIDE    = 3'd1,
    ST_BAD_MIRROR = 3'd2,
    ST_MISSING    = 3'd3,
    ST_REBUILD    = 3'd4,
    ST_LOAD_DONE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CLS_LOAD,
    CLS_DONE,
    CLS_MIRROR,
    CLS_STRIPE,
    CLS_PARITY
  } cls_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [63:0] base_offset;
    logic        present;
    logic [63:0] logical_addr;
    logic [31:0] read_size;
    logic [2:0]  mirror_select;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  stripe_sel;
    logic [63:0] phys_addr;
    logic [31:0] length_out;
    logic [63:0] rebuild_start;
    logic [3:0]  data_slot;
  } out_t;

  typedef struct packed {
    logic [63:0] chunk_start;
    logic [63:0] chunk_length;
    logic [4:0]  stripe_len_log2;
    logic [4:0]  stripe_count;
    logic [1:0]  copies_per_group;
    logic [3:0]  raid_profile;
  } cfg_t;

  typedef struct packed {
    logic [3:0] prof;
    logic [4:0] lg;
    logic [4:0] n;
    logic [1:0] sub;
    logic [4:0] d;
  } dcfg_t;

  typedef struct packed {
    cls_t             cls;
    status_t          status;
    logic [3:0]       slot;
    logic [63:0]      base;
    logic             present;
    logic [2:0]       mirror;
    logic [63:0]      offset;
    logic [SNR_W-1:0] snr;
    logic [19:0]      stripe_off;
    logic [31:0]      clip;
    logic [31:0]      size;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [4:0]       r1;
    logic [4:0]       r2;
    logic [SNR_W-1:0] q;
  } dstg_t;

  typedef struct packed {
    item_t              it;
    logic [4:0]         r1;
    logic [5:0]         idx;
    logic               ok;
    logic [63:0]        addend;
    logic [SNR_W+4:0]   prod;
  } sa_t;

  function automatic logic [2:0] mirror_limit(logic [3:0] prof);
    logic [2:0] lim;
    unique case (prof)
      PROF_SINGLE, PROF_RAID0: lim = 3'd1;
      PROF_RAID1, PROF_DUP, PROF_RAID10, PROF_RAID5: lim = 3'd2;
      PROF_RAID6, PROF_RAID1C3: lim = 3'd3;
      PROF_RAID1C4: lim = 3'd4;
      default: lim = 3'd1;
    endcase
    return lim;
  endfunction

  function automatic dcfg_t decode(cfg_t c, logic [8:0] max_stripes);
    dcfg_t r;
    logic [4:0] nd;
    r.prof = (c.raid_profile > PROF_RAID1C4) ? PROF_SINGLE : c.raid_profile;
    if (c.stripe_len_log2 < 5'(LG_MIN)) r.lg = 5'(LG_MIN);
    else if (c.stripe_len_log2 > 5'(LG_MAX)) r.lg = 5'(LG_MAX);
    else r.lg = c.stripe_len_log2;
    if (c.stripe_count == 5'd0) r.n = 5'd1;
    else if (9'(c.stripe_count) > max_stripes) r.n = max_stripes[4:0];
    else r.n = c.stripe_count;
    if (c.copies_per_group == 2'd0) r.sub = 2'd1;
    else if (c.copies_per_group > 2'd2) r.sub = 2'd2;
    else r.sub = c.copies_per_group;
    nd = 5'd1;
    priority if (r.prof == PROF_RAID0 || r.prof == PROF_RAID10) begin
      nd = (r.sub == 2'd2) ? (r.n >> 1) : r.n;
      if (nd == 5'd0) nd = 5'd1;
    end else if (r.prof == PROF_RAID5) begin
      nd = (r.n > 5'd1) ? r.n - 5'd1 : 5'd1;
    end else if (r.prof == PROF_RAID6) begin
      nd = (r.n > 5'd2) ? r.n - 5'd2 : 5'd1;
    end
    r.d = nd;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rcam_front.sv @@
`default_nettype none
module rcam_front import rcam_pkg::*; (
  input  in_t   in_data,
  input  cfg_t  cfg,
  input  dcfg_t dcfg,
  output item_t item
);

  logic [63:0] offset;
  logic [20:0] sl;
  logic [20:0] msk;
  logic [20:0] clip_full;
  logic [19:0] stripe_off;
  logic [2:0]  mirror;
  logic        outside;

  always_comb begin
    offset     = in_data.logical_addr - cfg.chunk_start;
    sl         = 21'd1 << dcfg.lg;
    msk        = sl - 21'd1;
    stripe_off = offset[19:0] & msk[19:0];
    clip_full  = sl - {1'b0, stripe_off};
    mirror     = (in_data.mirror_select == 3'd0) ? 3'd1 : in_data.mirror_select;
    outside    = (in_data.logical_addr < cfg.chunk_start) || (offset >= cfg.chunk_length);

    item.status     = ST_OK;
    item.slot       = in_data.slot;
    item.base       = in_data.base_offset;
    item.present    = in_data.present;
    item.mirror     = mirror;
    item.offset     = offset;
    item.snr        = SNR_W'(offset >> dcfg.lg);
    item.stripe_off = stripe_off;
    item.size       = in_data.read_size;
    item.clip    = ({11'd0, clip_full} > in_data.read_size) ? in_data.read_size
                                                            : {11'd0, clip_full};
    priority if (in_data.cmd == CMD_LOAD) begin
      item.cls = CLS_LOAD;
    end else if (outside) begin
      item.cls    = CLS_DONE;
      item.status = ST_OUTSIDE;
    end else if (mirror > mirror_limit(dcfg.prof)) begin
      item.cls    = CLS_DONE;
      item.status = ST_BAD_MIRROR;
    end else if (dcfg.prof == PROF_RAID0 || dcfg.prof == PROF_RAID10) begin
      item.cls = CLS_STRIPE;
    end else if (dcfg.prof == PROF_RAID5 || dcfg.prof == PROF_RAID6) begin
      item.cls = CLS_PARITY;
    end else begin
      item.cls = CLS_MIRROR;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rcam_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module rcam_fifo import rcam_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `RCAM_ASSERT(a_cnt_max, cnt_r <= CW'(DEPTH), "queue count above depth")
  `RCAM_ASSERT(a_empty_ptrs, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r), "queue pointers apart when empty")

endmodule
`default_nettype wire

@@ hw/rtl/rcam_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module rcam_back import rcam_pkg::*; #(
  parameter int MAX_STRIPES = MAX_STRIPES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  dcfg_t dcfg,
  input  logic  head_valid,
  input  item_t head,
  output logic  pop,
  output logic  out_valid,
  output out_t  out_data,
  input  logic  out_stall
);

  localparam int TW = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;

  logic [DIV_STG-1:0] dv_r;
  dstg_t              dd_r   [DIV_STG];
  dstg_t              dd_in  [DIV_STG];
  dstg_t              dd_nxt [DIV_STG];
  logic               sa_v_r;
  sa_t                sa_r, sa_nxt;
  logic [63:0]        base_r [MAX_STRIPES];
  logic [MAX_STRIPES-1:0] present_r;
  logic               out_valid_r;
  out_t               out_data_r, out_nxt;
  logic               en;
  logic               pres;
  logic [63:0]        base;
  logic [63:0]        fss;
  logic [5:0]         sum;
  logic               load_wr;

  function automatic dstg_t div_step(dstg_t s, int k, logic [4:0] d, logic [4:0] n);
    dstg_t      o;
    logic [5:0] t, t2;
    logic       qb;
    int         b;
    o = s;
    for (int j = 0; j < DIV_BITS; j++) begin
      b  = SNR_W - 1 - k * DIV_BITS - j;
      t  = {o.r1, o.it.snr[b]};
      qb = (t >= {1'b0, d});
      if (qb) t = t - {1'b0, d};
      o.r1 = t[4:0];
      t2 = {o.r2, qb};
      if (t2 >= {1'b0, n}) t2 = t2 - {1'b0, n};
      o.r2 = t2[4:0];
      o.q  = {o.q[SNR_W-2:0], qb};
    end
    return o;
  endfunction

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dd_in[0].it = head;
    dd_in[0].r1 = '0;
    dd_in[0].r2 = '0;
    dd_in[0].q  = '0;
    for (int k = 1; k < DIV_STG; k++) dd_in[k] = dd_r[k-1];
    for (int k = 0; k < DIV_STG; k++) dd_nxt[k] = div_step(dd_in[k], k, dcfg.d, dcfg.n);
  end

  always_comb begin
    sa_nxt.it   = dd_r[DIV_STG-1].it;
    sa_nxt.r1   = dd_r[DIV_STG-1].r1;
    sa_nxt.prod = (SNR_W + 5)'(dd_r[DIV_STG-1].q * dcfg.d);
    sa_nxt.addend = (64'(dd_r[DIV_STG-1].q) << dcfg.lg) | 64'(dd_r[DIV_STG-1].it.stripe_off);
    sum = {1'b0, dd_r[DIV_STG-1].r1} + {1'b0, dd_r[DIV_STG-1].r2};
    unique case (dd_r[DIV_STG-1].it.cls)
      CLS_STRIPE: begin
        sa_nxt.idx = ((dcfg.sub == 2'd2) ? {dd_r[DIV_STG-1].r1, 1'b0}
                                         : {1'b0, dd_r[DIV_STG-1].r1})
                   + 6'(dd_r[DIV_STG-1].it.mirror - 3'd1);
      end
      CLS_PARITY: sa_nxt.idx = (sum >= {1'b0, dcfg.n}) ? sum - {1'b0, dcfg.n} : sum;
      CLS_MIRROR: begin
        sa_nxt.idx    = 6'(dd_r[DIV_STG-1].it.mirror - 3'd1);
        sa_nxt.addend = dd_r[DIV_STG-1].it.offset;
      end
      default: sa_nxt.idx = 6'(dd_r[DIV_STG-1].it.slot);
    endcase
    sa_nxt.ok = (sa_nxt.idx < {1'b0, dcfg.n});
  end

  always_comb begin
    pres    = sa_r.ok && present_r[TW'(sa_r.idx)];
    base    = base_r[TW'(sa_r.idx)];
    fss     = cfg.chunk_start + (64'(sa_r.prod) << dcfg.lg);
    load_wr = en && sa_v_r && (sa_r.it.cls == CLS_LOAD)
              && (9'(sa_r.it.slot) < 9'(MAX_STRIPES));
    out_nxt = '0;
    unique case (sa_r.it.cls)
      CLS_LOAD: begin
        out_nxt.status     = ST_LOAD_DONE;
        out_nxt.stripe_sel = sa_r.it.slot;
      end
      CLS_DONE: out_nxt.status = sa_r.it.status;
      CLS_MIRROR, CLS_STRIPE: begin
        out_nxt.stripe_sel = sa_r.idx[3:0];
        if (pres) begin
          out_nxt.status     = ST_OK;
          out_nxt.phys_addr  = base + sa_r.addend;
          out_nxt.length_out = (sa_r.it.cls == CLS_MIRROR) ? sa_r.it.size : sa_r.it.clip;
        end else begin
          out_nxt.status = ST_MISSING;
        end
      end
      CLS_PARITY: begin
        out_nxt.stripe_sel = sa_r.idx[3:0];
        out_nxt.length_out = sa_r.it.clip;
        if (sa_r.it.mirror <= 3'd1 && pres) begin
          out_nxt.status    = ST_OK;
          out_nxt.phys_addr = base + sa_r.addend;
        end else begin
          out_nxt.status        = ST_REBUILD;
          out_nxt.rebuild_start = fss;
          out_nxt.data_slot     = sa_r.r1[3:0];
        end
      end
      default: out_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      sa_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      present_r   <= '0;
    end else begin
      if (en) begin
        dv_r        <= {dv_r[DIV_STG-2:0], pop};
        sa_v_r      <= dv_r[DIV_STG-1];
        out_valid_r <= sa_v_r;
      end
      if (load_wr) present_r[TW'(sa_r.it.slot)] <= sa_r.it.present;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STG; k++) dd_r[k] <= dd_nxt[k];
      sa_r       <= sa_nxt;
      out_data_r <= out_nxt;
    end
    if (load_wr) base_r[TW'(sa_r.it.slot)] <= sa_r.it.base;
  end

  `RCAM_ASSERT_NEXT(a_frozen, out_valid_r && out_stall, $stable(dv_r) && $stable(sa_v_r), "pipeline moved while output stalled")
  `RCAM_ASSERT(a_no_pop_stalled, (out_valid_r && out_stall) |-> !pop, "queue popped while output stalled")

endmodule
`default_nettype wire

@@ hw/rtl/raid_chunk_address_map.sv @@
// raid chunk address map
// input channel in_valid / in_stall / in_data: one transaction per item, either
// a stripe table load (cmd low) or a read translation (cmd high)
// output channel out_valid / out_stall / out_data: exactly one transaction per
// input transaction, in input order
// config port cfg_*: apb-style, 64-bit registers at byte address 8*index; the
// user must write them only while the block is idle (the block does not
// enforce this); cfg_pready is tied high
// throughput: one transaction per cycle while out_stall is low, set by the
// stripe-number divider, a 14-stage pipeline retiring 4 quotient bits per stage
// a 4-entry queue sits between the classifying front end and the pipeline;
// in_stall rises when the queue is full
// out_stall while out_valid is high freezes the whole back pipeline and holds out_data
// reset: registers take their reset values, all stripes read as missing,
// pipeline and queue empty
`default_nettype none
module raid_chunk_address_map import rcam_pkg::*; #(
  parameter int MAX_STRIPES = MAX_STRIPES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg_r;
  dcfg_t dcfg;
  item_t item, head;
  logic  full, not_empty, pop, wr;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dcfg = decode(cfg_r, 9'(MAX_STRIPES));
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_start      <= '0;
      cfg_r.chunk_length     <= '0;
      cfg_r.stripe_len_log2  <= 5'd16;
      cfg_r.stripe_count     <= 5'd1;
      cfg_r.copies_per_group <= 2'd1;
      cfg_r.raid_profile     <= PROF_SINGLE;
    end else if (wr) begin
      unique case (cfg_paddr[5:3])
        REG_CHUNK_START: cfg_r.chunk_start      <= cfg_pwdata;
        REG_CHUNK_LEN:   cfg_r.chunk_length     <= cfg_pwdata;
        REG_STRIPE_LG:   cfg_r.stripe_len_log2  <= cfg_pwdata[4:0];
        REG_STRIPE_CNT:  cfg_r.stripe_count     <= cfg_pwdata[4:0];
        REG_COPIES:      cfg_r.copies_per_group <= cfg_pwdata[1:0];
        REG_PROFILE:     cfg_r.raid_profile     <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_CHUNK_START: cfg_prdata = cfg_r.chunk_start;
      REG_CHUNK_LEN:   cfg_prdata = cfg_r.chunk_length;
      REG_STRIPE_LG:   cfg_prdata = 64'(cfg_r.stripe_len_log2);
      REG_STRIPE_CNT:  cfg_prdata = 64'(cfg_r.stripe_count);
      REG_COPIES:      cfg_prdata = 64'(cfg_r.copies_per_group);
      REG_PROFILE:     cfg_prdata = 64'(cfg_r.raid_profile);
      default:         cfg_prdata = '0;
    endcase
  end

  rcam_front u_front (
    .in_data (in_data),
    .cfg     (cfg_r),
    .dcfg    (dcfg),
    .item    (item)
  );

  rcam_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  rcam_back #(.MAX_STRIPES(MAX_STRIPES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .dcfg       (dcfg),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule
`default_nettype wire
